// ----- sv/irle_pkg.sv -----
// Shared types and constants for the IR bit run-length encoder.
// Holds the field widths, marker codes, FSM states and the run record struct.
// No dependencies; imported by every module of the block.
package irle_pkg;

    // Result arithmetic width; the duration is truncated to this many bits.
    localparam int DURATION_BITS = 24;

    // Field and register widths.
    localparam int LEN_W      = 8;
    localparam int DATA_W     = 40;
    localparam int MARK_W     = 8;
    localparam int DUR_W      = 24;
    localparam int BIT_TIME_W = 16;
    localparam int COUNT_W    = 16;
    localparam int PROD_W     = COUNT_W + BIT_TIME_W;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = BIT_TIME_W;

    // Lane split: one lane per sampled byte.
    localparam int LANE_W    = 8;
    localparam int NUM_LANES = DATA_W / LANE_W;
    localparam int LEFT_W    = $clog2(DATA_W + 1);

    // Packet and marker codes.
    localparam logic [LEN_W-1:0]  PKT_LEN_OK = LEN_W'(8);
    localparam logic [MARK_W-1:0] MARK_START = MARK_W'(1);
    localparam logic [MARK_W-1:0] MARK_END   = MARK_W'(10);

    // Run constants.
    localparam logic [COUNT_W-1:0] START_SPACE_BITS = COUNT_W'(4);
    localparam logic [COUNT_W-1:0] RUN_MAX          = '1;
    localparam logic [COUNT_W-1:0] RUN_ONE          = COUNT_W'(1);

    // Register reset values.
    localparam logic [BIT_TIME_W-1:0] BIT_TIME_RESET = BIT_TIME_W'(250);

    // Mask applied to the product before it is cut to the field width.
    localparam logic [PROD_W-1:0] DUR_MASK = PROD_W'((64'd1 << DURATION_BITS) - 64'd1);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RX_ENABLE = 1'b0,
        CFG_BIT_TIME  = 1'b1
    } t_cfg_idx;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_WALK,
        ST_END,
        ST_DRAIN
    } t_state;

    // One finished run handed from the sequencer to the output stage.
    typedef struct packed {
        logic               valid;
        logic               level;
        logic [COUNT_W-1:0] count;
        logic               last;
    } t_run;

endpackage

// ----- sv/irle_lane.sv -----
// One byte lane of the encoder: inverts the sampled bits into line levels
// and flags every bit whose level differs from the bit before it.
// Depends on irle_pkg.
module irle_lane (
    input  logic [irle_pkg::LANE_W-1:0] i_byte,
    input  logic                        i_prev_level,
    output logic [irle_pkg::LANE_W-1:0] o_level,
    output logic [irle_pkg::LANE_W-1:0] o_change
);
    import irle_pkg::*;

    // A sampled one is a space on the line, so the level is the inverse.
    assign o_level = ~i_byte;

    // The top bit compares against the last bit of the preceding lane.
    always_comb begin
        o_change[LANE_W-1] = o_level[LANE_W-1] ^ i_prev_level;
        for (int j = 0; j < LANE_W - 1; j++) begin
            o_change[j] = o_level[j] ^ o_level[j+1];
        end
    end

endmodule

// ----- sv/irle_merge.sv -----
// Merging sequencer: walks the lane results one bit a cycle while the output
// takes its runs, keeps the run state across packets and hands finished runs
// on through a pending slot. Depends on irle_pkg.
module irle_merge (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [irle_pkg::LEN_W-1:0]      i_packet_length,
    input  logic [irle_pkg::MARK_W-1:0]     i_marker_byte,
    input  logic                            i_rx_enable,
    output logic                            o_prev_level,
    input  logic [irle_pkg::DATA_W-1:0]     i_level,
    input  logic [irle_pkg::DATA_W-1:0]     i_change,
    input  logic                            i_out_free,
    output irle_pkg::t_run                  o_push
);
    import irle_pkg::*;

    t_state              r_state, n_state;
    logic [DATA_W-1:0]   r_lvl_sh, n_lvl_sh;
    logic [DATA_W-1:0]   r_chg_sh, n_chg_sh;
    logic [LEFT_W-1:0]   r_left, n_left;
    logic                r_end, n_end;
    logic [COUNT_W-1:0]  r_count, n_count;
    logic                r_level, n_level;
    logic                r_space_first, n_space_first;
    t_run                r_pend, n_pend;

    logic                accept;
    logic                start_hit;
    logic                emit_ok;
    logic                new_valid;
    logic                new_level;
    logic [COUNT_W-1:0]  new_count;
    logic                flush;
    logic                emit_needed;
    logic [COUNT_W-1:0]  count_inc;

    // Only one packet is in work at a time; a dropped packet leaves the sequencer idle.
    assign o_in_stall = (r_state != ST_IDLE);
    assign accept     = i_in_valid && (r_state == ST_IDLE);
    assign start_hit  = (i_marker_byte == MARK_START) && r_space_first;

    // A frame start forces the level to space before the first sampled bit.
    assign o_prev_level = start_hit ? 1'b0 : r_level;

    // A new run may enter unless the pending run has nowhere to go.
    assign emit_ok     = !r_pend.valid || i_out_free;
    assign emit_needed = r_chg_sh[DATA_W-1] && (r_count != '0);
    assign count_inc   = (r_count == RUN_MAX) ? r_count : r_count + RUN_ONE;

    // Next state and run bookkeeping.
    always_comb begin
        n_state       = r_state;
        n_lvl_sh      = r_lvl_sh;
        n_chg_sh      = r_chg_sh;
        n_left        = r_left;
        n_end         = r_end;
        n_count       = r_count;
        n_level       = r_level;
        n_space_first = r_space_first;
        new_valid     = 1'b0;
        new_level     = r_level;
        new_count     = r_count;
        flush         = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (accept && i_rx_enable && (i_packet_length == PKT_LEN_OK)) begin
                    n_lvl_sh = i_level;
                    n_chg_sh = i_change;
                    n_left   = LEFT_W'(DATA_W);
                    n_end    = (i_marker_byte == MARK_END);
                    n_state  = start_hit ? ST_START : ST_WALK;
                end
            end
            ST_START: begin
                if (emit_ok) begin
                    new_valid = 1'b1;
                    new_level = 1'b0;
                    new_count = START_SPACE_BITS;
                    n_level   = 1'b0;
                    n_count   = '0;
                    n_state   = ST_WALK;
                end
            end
            ST_WALK: begin
                if (!emit_needed || emit_ok) begin
                    new_valid = emit_needed;
                    if (r_chg_sh[DATA_W-1]) begin
                        n_level = r_lvl_sh[DATA_W-1];
                    end
                    n_count  = emit_needed ? RUN_ONE : count_inc;
                    n_lvl_sh = {r_lvl_sh[DATA_W-2:0], 1'b0};
                    n_chg_sh = {r_chg_sh[DATA_W-2:0], 1'b0};
                    n_left   = r_left - LEFT_W'(1);
                    if (r_left == LEFT_W'(1)) begin
                        n_state = ST_END;
                    end
                end
            end
            ST_END: begin
                if (!r_end) begin
                    n_state = ST_DRAIN;
                end else if (r_count == '0) begin
                    n_space_first = r_level;
                    n_state       = ST_DRAIN;
                end else if (emit_ok) begin
                    new_valid     = 1'b1;
                    n_count       = '0;
                    n_space_first = r_level;
                    n_state       = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!r_pend.valid) begin
                    n_state = ST_IDLE;
                end else if (i_out_free) begin
                    flush   = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // The pending slot holds back one run so that the last one can be marked.
    always_comb begin
        o_push = '0;
        n_pend = r_pend;
        if (new_valid) begin
            o_push       = r_pend;
            o_push.last  = 1'b0;
            n_pend.valid = 1'b1;
            n_pend.level = new_level;
            n_pend.count = new_count;
            n_pend.last  = 1'b0;
        end else if (flush) begin
            o_push       = r_pend;
            o_push.last  = 1'b1;
            n_pend.valid = 1'b0;
        end
    end

    // Control and run state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_left        <= '0;
            r_count       <= '0;
            r_level       <= 1'b0;
            r_space_first <= 1'b1;
            r_pend        <= '0;
        end else begin
            r_state       <= n_state;
            r_left        <= n_left;
            r_count       <= n_count;
            r_level       <= n_level;
            r_space_first <= n_space_first;
            r_pend        <= n_pend;
        end
    end

    // Lane results and packet flags.
    always_ff @(posedge i_clk) begin
        r_lvl_sh <= n_lvl_sh;
        r_chg_sh <= n_chg_sh;
        r_end    <= n_end;
    end

endmodule

// ----- sv/irle_emit.sv -----
// Output stage: scales each run by the bit time and holds the result
// in the output register until the transfer completes.
// Depends on irle_pkg.
module irle_emit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  irle_pkg::t_run                    i_push,
    input  logic [irle_pkg::BIT_TIME_W-1:0]   i_bit_time,
    input  logic                              i_out_stall,
    output logic                              o_free,
    output logic                              o_out_valid,
    output logic                              o_is_pulse,
    output logic [irle_pkg::DUR_W-1:0]        o_duration,
    output logic                              o_last_of_run
);
    import irle_pkg::*;

    logic              r_valid;
    logic              r_is_pulse;
    logic [DUR_W-1:0]  r_duration;
    logic              r_last;
    logic [PROD_W-1:0] product;

    // Run length times bit time, truncated to the duration width.
    assign product = (PROD_W'(i_push.count) * PROD_W'(i_bit_time)) & DUR_MASK;

    // The register can load when it is empty or its transfer completes now.
    assign o_free = !r_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push.valid) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    // Payload loads only on a push.
    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_is_pulse <= i_push.level;
            r_duration <= product[DUR_W-1:0];
            r_last     <= i_push.last;
        end
    end

    assign o_out_valid   = r_valid;
    assign o_is_pulse    = r_is_pulse;
    assign o_duration    = r_duration;
    assign o_last_of_run = r_last;

endmodule

// ----- sv/ir_bit_run_length_encoder_unit.sv -----
// Each run waits in a one-run slot until the next run or the end of the packet marks it.
// A processed packet goes through accept, the start space on a frame start, 40 bit steps,
// the end flush and drain, the walk stepping one bit a cycle through the sequencer;
// the input stays stalled until the packet is through. A dropped packet does not stall it.
// Output stalls pause the walk at each run boundary.
// Reset (synchronous, active low) clears the run state, sets the start flag and
// returns reception to closed and the bit time to 250.
module ir_bit_run_length_encoder_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [irle_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [irle_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [irle_pkg::LEN_W-1:0]         i_packet_length,
    input  logic [irle_pkg::DATA_W-1:0]        i_bit_data,
    input  logic [irle_pkg::MARK_W-1:0]        i_marker_byte,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_is_pulse,
    output logic [irle_pkg::DUR_W-1:0]         o_duration,
    output logic                               o_last_of_run
);
    import irle_pkg::*;

    logic                  r_rx_enable;
    logic [BIT_TIME_W-1:0] r_bit_time;
    logic [DATA_W-1:0]     lane_level;
    logic [DATA_W-1:0]     lane_change;
    logic                  merge_prev;
    logic                  out_free;
    t_run                  push;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_enable <= 1'b0;
            r_bit_time  <= BIT_TIME_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_RX_ENABLE: r_rx_enable <= i_cfg_data[0];
                CFG_BIT_TIME:  r_bit_time  <= i_cfg_data[BIT_TIME_W-1:0];
            endcase
        end
    end

    // Byte lanes, most significant byte first; each chains to the one above.
    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        logic prev;
        if (g == NUM_LANES - 1) begin : g_top
            assign prev = merge_prev;
        end else begin : g_chain
            assign prev = lane_level[(g+1)*LANE_W];
        end
        irle_lane u_lane (
            .i_byte       (i_bit_data[g*LANE_W +: LANE_W]),
            .i_prev_level (prev),
            .o_level      (lane_level[g*LANE_W +: LANE_W]),
            .o_change     (lane_change[g*LANE_W +: LANE_W])
        );
    end

    // Sequencer that merges the lane results into runs.
    irle_merge u_merge (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_packet_length (i_packet_length),
        .i_marker_byte   (i_marker_byte),
        .i_rx_enable     (r_rx_enable),
        .o_prev_level    (merge_prev),
        .i_level         (lane_level),
        .i_change        (lane_change),
        .i_out_free      (out_free),
        .o_push          (push)
    );

    // Duration scaling and output register.
    irle_emit u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_bit_time    (r_bit_time),
        .i_out_stall   (i_out_stall),
        .o_free        (out_free),
        .o_out_valid   (o_out_valid),
        .o_is_pulse    (o_is_pulse),
        .o_duration    (o_duration),
        .o_last_of_run (o_last_of_run)
    );

endmodule

// ----- sv/irle_checker.sv -----
// Port-level checks for the IR bit run-length encoder, bound to the top level.
// Depends on irle_pkg and ir_bit_run_length_encoder_unit.
module irle_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic [irle_pkg::LEN_W-1:0]    i_packet_length,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic                          o_is_pulse,
    input logic [irle_pkg::DUR_W-1:0]    o_duration,
    input logic                          o_last_of_run
);
    import irle_pkg::*;

    // A stalled result holds until its transfer completes.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_is_pulse)
            && $stable(o_duration) && $stable(o_last_of_run))
        else $error("stalled result changed");

    // Reset empties the output register.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A packet of the wrong length is dropped at once.
    a_drop_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_packet_length != PKT_LEN_OK) |=> !o_in_stall)
        else $error("dropped packet kept the input stalled");

    // A result that is not the last of its packet only shows while the packet is in work.
    a_busy_until_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last_of_run |-> o_in_stall)
        else $error("input open before the final result of a packet");

endmodule

bind ir_bit_run_length_encoder_unit irle_checker u_irle_checker (.*);

// ----- dv/ir_bit_run_length_encoder_unit_test.sv -----
// Self-checking testbench for the IR bit run-length encoder unit.
// Runs directed and random packets through a clocked driver and monitor and checks every run.
// Depends on irle_pkg and ir_bit_run_length_encoder_unit.
module ir_bit_run_length_encoder_unit_test;

    import irle_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 64;
    localparam int LONG_RUN_PKTS = 80;
    localparam int PHASE_PKTS    = 30;

    // One received packet as it is offered to the block.
    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [DATA_W-1:0] bits;
        logic [MARK_W-1:0] marker;
    } t_ir_packet;

    // One pulse or space run as the block should emit it.
    typedef struct packed {
        logic             pulse;
        logic [DUR_W-1:0] dur;
        logic             last;
    } t_ir_run;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    t_cfg_idx              i_cfg_index = CFG_RX_ENABLE;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [LEN_W-1:0]      i_packet_length = '0;
    logic [DATA_W-1:0]     i_bit_data = '0;
    logic [MARK_W-1:0]     i_marker_byte = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic                  o_is_pulse;
    logic [DUR_W-1:0]      o_duration;
    logic                  o_last_of_run;

    t_ir_packet pending_packets[$];
    t_ir_run    expected_runs[$];

    // Predictor copy of the configuration and the run state.
    logic                  rx_open = 1'b0;
    logic [BIT_TIME_W-1:0] bit_period = BIT_TIME_RESET;
    logic [COUNT_W-1:0]    run_cnt = '0;
    logic                  line_level = 1'b0;
    logic                  start_flag = 1'b1;

    int          sender_pct = 0;
    int          stall_pct = 0;
    int          mismatch_count = 0;
    int unsigned cycle_count = 0;

    ir_bit_run_length_encoder_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_packet_length (i_packet_length),
        .i_bit_data      (i_bit_data),
        .i_marker_byte   (i_marker_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_is_pulse      (o_is_pulse),
        .o_duration      (o_duration),
        .o_last_of_run   (o_last_of_run)
    );

    // Clock generation.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The run that is open now, scaled by the bit time and cut to the field width.
    function automatic t_ir_run close_run();
        t_ir_run            r;
        logic [PROD_W-1:0]  prod;
        prod    = run_cnt * bit_period;
        r.pulse = line_level;
        r.dur   = prod[DUR_W-1:0];
        r.last  = 1'b0;
        return r;
    endfunction

    // Work out the runs that one accepted packet produces and queue them.
    function automatic void encode_packet(t_ir_packet p);
        t_ir_run runs[$];
        logic    lvl;
        int      b;
        if (!rx_open || p.len != PKT_LEN_OK) return;
        // A frame start drops the open run and emits the fixed leading space.
        if (p.marker == MARK_START && start_flag) begin
            line_level = 1'b0;
            run_cnt    = START_SPACE_BITS;
            runs.push_back(close_run());
            run_cnt    = '0;
        end
        // Walk the sampled bits, most significant first; a sample of 0 is a pulse.
        for (b = DATA_W - 1; b >= 0; b--) begin
            lvl = ~p.bits[b];
            if (lvl != line_level) begin
                if (run_cnt != '0) begin
                    runs.push_back(close_run());
                    run_cnt = '0;
                end
                line_level = lvl;
            end
            if (run_cnt != RUN_MAX) run_cnt = run_cnt + RUN_ONE;
        end
        // A frame end flushes the open run and records the level for the next start.
        if (p.marker == MARK_END) begin
            if (run_cnt != '0) begin
                runs.push_back(close_run());
                run_cnt = '0;
            end
            start_flag = line_level;
        end
        for (b = 0; b < runs.size(); b++) begin
            runs[b].last = (b == runs.size() - 1);
            expected_runs.push_back(runs[b]);
        end
    endfunction

    // Random sample bits: either raw noise or a run-structured pattern.
    function automatic logic [DATA_W-1:0] random_bits();
        logic [63:0]       raw;
        logic [DATA_W-1:0] bits;
        logic              lvl;
        int                b;
        raw = {$urandom(), $urandom()};
        if ($urandom_range(2) == 0) return raw[DATA_W-1:0];
        lvl = raw[63];
        for (b = DATA_W - 1; b >= 0; b--) begin
            if ($urandom_range(5) == 0) lvl = ~lvl;
            bits[b] = lvl;
        end
        return bits;
    endfunction

    function automatic void push_packet(logic [LEN_W-1:0] len, logic [DATA_W-1:0] bits,
                                        logic [MARK_W-1:0] marker);
        t_ir_packet p;
        p.len    = len;
        p.bits   = bits;
        p.marker = marker;
        pending_packets.push_back(p);
    endfunction

    // Register write; the predictor copy follows at the edge that takes it.
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_RX_ENABLE) rx_open = val[0];
        else bit_period = val[BIT_TIME_W-1:0];
    endtask

    // Wait until every packet is taken and every run has come, then let the block settle.
    task automatic wait_idle();
        do begin
            @(posedge i_clk);
        end while (pending_packets.size() != 0 || i_in_valid || expected_runs.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic void report_bad(string what, t_ir_run want);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s: expected pulse=%0b dur=%0d last=%0b, got pulse=%0b dur=%0d last=%0b",
                     what, want.pulse, want.dur, want.last,
                     o_is_pulse, o_duration, o_last_of_run);
    endfunction

    // Packet driver: predicts each transfer and offers the next packet when the slot frees.
    always @(posedge i_clk) begin
        t_ir_packet nxt;
        logic       hold_off;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall)
                encode_packet('{len: i_packet_length, bits: i_bit_data, marker: i_marker_byte});
            if (!i_in_valid || !o_in_stall) begin
                hold_off = (sender_pct != 0) && (cycle_count % 512 >= 64) &&
                           ($urandom_range(99) < sender_pct);
                if (pending_packets.size() != 0 && !hold_off) begin
                    nxt = pending_packets.pop_front();
                    i_packet_length <= nxt.len;
                    i_bit_data      <= nxt.bits;
                    i_marker_byte   <= nxt.marker;
                    i_in_valid      <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Run monitor: checks each transfer against the oldest expected run.
    always @(posedge i_clk) begin
        t_ir_run want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_runs.size() == 0) begin
                    want = '0;
                    report_bad("Unexpected run", want);
                end else begin
                    want = expected_runs.pop_front();
                    if (o_is_pulse !== want.pulse || o_duration !== want.dur ||
                        o_last_of_run !== want.last)
                        report_bad("Run mismatch", want);
                end
            end
            i_out_stall <= (stall_pct != 0) && (cycle_count % 512 >= 64) &&
                           ($urandom_range(99) < stall_pct);
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Stimulus sequence.
    initial begin
        int               ph;
        int               processed;
        int               mids;
        int               n;
        logic [LEN_W-1:0] len;
        logic [CFG_DATA_W-1:0] period;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reception closed after reset: these packets must vanish.
        push_packet(PKT_LEN_OK, 40'h00FF00FF00, MARK_START);
        push_packet(PKT_LEN_OK, random_bits(), MARK_END);
        wait_idle();
        write_reg(CFG_RX_ENABLE, 16'd1);

        // Directed packets at the reset bit time.
        push_packet(PKT_LEN_OK, 40'hF0F0F0F0F0, MARK_START);
        push_packet(PKT_LEN_OK, 40'h0000000000, 8'd0);
        push_packet(PKT_LEN_OK, 40'hFFFFFFFFFF, 8'd0);
        push_packet(PKT_LEN_OK, 40'hAAAAAAAAAA, 8'd0);
        push_packet(PKT_LEN_OK, 40'h5555555555, 8'd255);
        push_packet(8'd0, random_bits(), MARK_END);
        push_packet(8'd7, random_bits(), MARK_START);
        push_packet(8'd9, random_bits(), 8'd0);
        push_packet(8'd255, 40'hFFFFFFFFFF, MARK_END);
        push_packet(PKT_LEN_OK, 40'h123456789A, MARK_END);
        push_packet(PKT_LEN_OK, 40'hFFFF0000FF, MARK_START);
        push_packet(PKT_LEN_OK, 40'h00000000FF, MARK_END);
        // Start flag now clear, so this start marker only walks the bits.
        push_packet(PKT_LEN_OK, 40'h0F0F0F0F0F, MARK_START);
        push_packet(PKT_LEN_OK, 40'h8000000001, MARK_END);
        push_packet(PKT_LEN_OK, 40'hFFFFFFFFFE, 8'd0);
        wait_idle();

        // Widest bit time, and a frame split by closing and reopening reception.
        write_reg(CFG_BIT_TIME, 16'hFFFF);
        push_packet(PKT_LEN_OK, 40'hFF00000000, MARK_START);
        push_packet(PKT_LEN_OK, 40'h0000FFFF00, MARK_END);
        push_packet(PKT_LEN_OK, 40'hF00000000F, MARK_START);
        wait_idle();
        write_reg(CFG_RX_ENABLE, 16'd0);
        push_packet(PKT_LEN_OK, 40'h000000FFFF, MARK_END);
        wait_idle();
        write_reg(CFG_RX_ENABLE, 16'd1);
        push_packet(PKT_LEN_OK, 40'h000000FFFF, MARK_END);
        wait_idle();

        // One pulse that spans many packets, then flushed.
        for (n = 0; n < LONG_RUN_PKTS; n++)
            push_packet(PKT_LEN_OK, 40'h0000000000, 8'd0);
        push_packet(PKT_LEN_OK, 40'h0000000000, MARK_END);
        wait_idle();

        // Random phases, each with its own pacing and bit time.
        for (ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin sender_pct = 0;  stall_pct = 0;  end
                1: begin sender_pct = 83; stall_pct = 0;  end
                2: begin sender_pct = 0;  stall_pct = 83; end
                default: begin sender_pct = 12; stall_pct = 12; end
            endcase
            case (ph)
                0: period = 16'd1;
                1: period = 16'd250;
                2: period = 16'($urandom_range(65535, 1));
                3: period = 16'hFFFF;
                4: period = 16'($urandom_range(16, 1));
                5: period = 16'($urandom_range(4095, 1));
                6: period = 16'd1000;
                default: period = 16'($urandom_range(65535, 1));
            endcase
            write_reg(CFG_BIT_TIME, period);

            // A closed window in one phase: its packets are dropped whole.
            if (ph == 5) begin
                write_reg(CFG_RX_ENABLE, 16'd0);
                repeat (6) push_packet(PKT_LEN_OK, random_bits(), MARK_W'($urandom_range(255)));
                wait_idle();
                write_reg(CFG_RX_ENABLE, 16'd1);
            end

            // Mostly well-formed frames with random content, the rest noise.
            processed = 0;
            while (processed < PHASE_PKTS) begin
                if ($urandom_range(99) < 80) begin
                    push_packet(PKT_LEN_OK, random_bits(), MARK_START);
                    mids = $urandom_range(3);
                    repeat (mids)
                        push_packet(PKT_LEN_OK, random_bits(), MARK_W'($urandom_range(255)));
                    push_packet(PKT_LEN_OK, random_bits(), MARK_END);
                    processed += mids + 2;
                end else begin
                    len = ($urandom_range(1) == 1) ? PKT_LEN_OK : LEN_W'($urandom_range(255));
                    push_packet(len, random_bits(), MARK_W'($urandom_range(255)));
                    if (len == PKT_LEN_OK) processed++;
                end
            end
            wait_idle();
        end

        if (mismatch_count == 0 && expected_runs.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
